// File: rtl/streaming_aggregate_accumulator_defines.svh
// assertion macros shared by the accumulator rtl
`ifndef STREAMING_AGGREGATE_ACCUMULATOR_DEFINES_SVH
`define STREAMING_AGGREGATE_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SAA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SAA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SAA_ASSERT(lbl, prop, msg)
`define SAA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/saa_pkg.sv
// types, codes and saturating helpers for the aggregate accumulator
package saa_pkg;

	localparam int VAL_W  = 64;
	localparam int FRAC_W = 32;
	localparam int CNT_W  = 32;
	localparam int PROD_W = 128;

	localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [CNT_W-1:0] CMAX = '1;

	// opcodes of an input beat
	localparam logic [2:0] OPC_ADD   = 3'd0;
	localparam logic [2:0] OPC_WAVG  = 3'd1;
	localparam logic [2:0] OPC_MERGE = 3'd2;
	localparam logic [2:0] OPC_READ  = 3'd3;
	localparam logic [2:0] OPC_CLEAR = 3'd4;

	// function modes
	localparam logic [3:0] MODE_COUNT    = 4'd0;
	localparam logic [3:0] MODE_SUM      = 4'd1;
	localparam logic [3:0] MODE_AVG      = 4'd2;
	localparam logic [3:0] MODE_MIN      = 4'd3;
	localparam logic [3:0] MODE_MAX      = 4'd4;
	localparam logic [3:0] MODE_STDDEV   = 4'd5;
	localparam logic [3:0] MODE_VARIANCE = 4'd6;
	localparam logic [3:0] MODE_DISTINCT = 4'd7;
	localparam logic [3:0] MODE_MEDIAN   = 4'd8;
	localparam logic [3:0] MODE_PCTILE   = 4'd9;
	localparam logic [3:0] MODE_FIRST    = 4'd10;
	localparam logic [3:0] MODE_LAST     = 4'd11;

	// result kinds
	localparam logic [1:0] KIND_FIXED = 2'd0;
	localparam logic [1:0] KIND_INT   = 2'd1;
	localparam logic [1:0] KIND_NULL  = 2'd2;

	typedef struct packed {
		logic [2:0]              opcode;
		logic signed [VAL_W-1:0] sample_value;
		logic [31:0]             weight;
		logic [62:0]             other_spread;
	} in_beat_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [1:0]              result_kind;
		logic                    saturated;
	} out_beat_t;

	typedef enum logic [1:0] {
		IT_MUL  = 2'd0,
		IT_DIV  = 2'd1,
		IT_ROOT = 2'd2
	} iter_op_t;

	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic             ovf;
	} sat_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             ovf;
	} cnt_sat_t;

	function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] x);
		return x[VAL_W-1] ? (~x + VAL_W'(1)) : x;
	endfunction

	function automatic sat_t sat_add(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		sat_t r;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		r.ovf = s[VAL_W] ^ s[VAL_W-1];
		r.val = r.ovf ? (s[VAL_W] ? VMIN : VMAX) : s[VAL_W-1:0];
		return r;
	endfunction

	function automatic sat_t sat_sub(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		sat_t r;
		s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		r.ovf = s[VAL_W] ^ s[VAL_W-1];
		r.val = r.ovf ? (s[VAL_W] ? VMIN : VMAX) : s[VAL_W-1:0];
		return r;
	endfunction

	// signed value from a sign and a wide magnitude
	function automatic sat_t from_mag(input logic neg, input logic hi_nz,
			input logic [VAL_W-1:0] lo);
		sat_t r;
		if (neg) begin
			r.ovf = hi_nz || (lo > {1'b1, {(VAL_W-1){1'b0}}});
			r.val = r.ovf ? VMIN : (~lo + VAL_W'(1));
		end else begin
			r.ovf = hi_nz || lo[VAL_W-1];
			r.val = r.ovf ? VMAX : lo;
		end
		return r;
	endfunction

	function automatic cnt_sat_t add_count(input logic [CNT_W-1:0] c, input logic [31:0] w);
		logic [CNT_W:0] t;
		cnt_sat_t r;
		t = {1'b0, c} + {1'b0, w};
		r.ovf = t[CNT_W];
		r.cnt = t[CNT_W] ? CMAX : t[CNT_W-1:0];
		return r;
	endfunction

endpackage

// File: rtl/saa_iter.sv
// shared bit-serial multiply, restoring divide and digit square root unit
module saa_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  saa_pkg::iter_cmd_t  cmd,
	input  logic [127:0]        opa,
	input  logic [63:0]         opb,
	output logic [127:0]        res,
	output saa_pkg::iter_stat_t stat
);

	saa_pkg::iter_op_t op_q;
	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [127:0] x_q;
	logic [63:0] b_q;
	logic [66:0] r_q;

	logic [64:0]  mul_sum;
	logic [64:0]  div_sh;
	logic         div_ge;
	logic [64:0]  div_rem;
	logic [66:0]  root_sh;
	logic [66:0]  root_trial;
	logic         root_ge;
	logic [66:0]  root_rem;

	// one step of each operation
	always_comb begin
		mul_sum    = {1'b0, x_q[127:64]} + (x_q[0] ? {1'b0, b_q} : 65'd0);
		div_sh     = {r_q[63:0], x_q[127]};
		div_ge     = div_sh >= {1'b0, b_q};
		div_rem    = div_ge ? (div_sh - {1'b0, b_q}) : div_sh;
		root_sh    = {r_q[64:0], x_q[127:126]};
		root_trial = {1'b0, b_q, 2'b01};
		root_ge    = root_sh >= root_trial;
		root_rem   = root_ge ? (root_sh - root_trial) : root_sh;
	end

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= saa_pkg::IT_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q   <= cmd.op;
				busy_q <= 1'b1;
				cnt_q  <= (cmd.op == saa_pkg::IT_DIV) ? 7'd127 : 7'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= (cmd.op == saa_pkg::IT_MUL) ? {64'd0, opa[63:0]} : opa;
			b_q <= (cmd.op == saa_pkg::IT_ROOT) ? 64'd0 : opb;
			r_q <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				saa_pkg::IT_MUL: begin
					x_q <= {mul_sum, x_q[63:1]};
				end
				saa_pkg::IT_DIV: begin
					x_q <= {x_q[126:0], div_ge};
					r_q <= {3'd0, div_rem[63:0]};
				end
				saa_pkg::IT_ROOT: begin
					x_q <= {x_q[125:0], 2'b00};
					b_q <= {b_q[62:0], root_ge};
					r_q <= root_rem;
				end
				default: begin
					x_q <= x_q;
				end
			endcase
		end
	end

	assign res       = (op_q == saa_pkg::IT_ROOT) ? {64'd0, b_q} : x_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/saa_cfg.sv
// apb register file holding the function mode
module saa_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [3:0]  mode
);

	localparam logic REG_MODE = 1'b0;

	logic [3:0] mode_q;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= saa_pkg::MODE_SUM;
		end else if (psel && penable && pwrite && paddr[2] == REG_MODE) begin
			mode_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == REG_MODE) ? {28'd0, mode_q} : 32'd0;
	assign pready = 1'b1;
	assign mode   = mode_q;

endmodule

// File: rtl/streaming_aggregate_accumulator.sv
// top level: sequencer, aggregate state and beat handshakes
//
// One aggregate column in signed Q32.32 with saturating sums. The block
// takes one input beat at a time; item_stall stays high until the result
// has been placed in the output register, which may still be waiting when
// the next beat is taken. All multiplies, divides and the square root run
// on one shared iterative unit at one bit per cycle. Sum, count, min, max,
// first and last do not use the unit; an added sample in variance or
// stddev mode takes a divide and a multiply, a weighted average one
// multiply and a variance merge four multiplies and two divides; a
// finalise for average or variance adds a divide and for stddev a divide
// and a root.
`include "streaming_aggregate_accumulator_defines.svh"

module streaming_aggregate_accumulator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                item_valid,
	output logic                item_stall,
	input  saa_pkg::in_beat_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output saa_pkg::out_beat_t  result
);

	typedef enum logic [15:0] {
		ST_IDLE   = 16'h0001,
		ST_EXEC   = 16'h0002,
		ST_W_DIV  = 16'h0004,
		ST_W_D2   = 16'h0008,
		ST_W_MUL  = 16'h0010,
		ST_A_MUL  = 16'h0020,
		ST_M_MUL1 = 16'h0040,
		ST_M_DIV1 = 16'h0080,
		ST_M_SQ   = 16'h0100,
		ST_M_MUL2 = 16'h0200,
		ST_M_DIV2 = 16'h0400,
		ST_M_MUL3 = 16'h0800,
		ST_FIN    = 16'h1000,
		ST_F_DIV  = 16'h2000,
		ST_F_ROOT = 16'h4000,
		ST_OUT    = 16'h8000
	} seq_state_t;

	seq_state_t state_q, state_d;
	logic       launch_q, launch_d;
	logic [3:0] mode_q;

	// beat payload
	logic [2:0]  op_q;
	logic [63:0] v_q;
	logic [31:0] w_q;
	logic [62:0] os_q;

	// working registers
	logic [63:0] delta_q, delta_d;
	logic [63:0] t_q, t_d;
	logic [31:0] n_q, n_d;
	logic [32:0] total_q, total_d;
	logic        qnz_q, qnz_d;
	logic [63:0] ores_q, ores_d;
	logic [1:0]  okind_q, okind_d;

	// aggregate state
	logic [63:0] sum_q, sum_d;
	logic [31:0] count_q, count_d;
	logic [63:0] min_q, min_d;
	logic [63:0] max_q, max_d;
	logic [63:0] mean_q, mean_d;
	logic [63:0] spread_q, spread_d;
	logic [63:0] first_q, first_d;
	logic [63:0] last_q, last_d;
	logic        have_first_q, have_first_d;
	logic        ovf_q, ovf_d;
	logic        ovf_set;
	logic        clr;

	// output register
	logic               rvalid_q, rvalid_d;
	saa_pkg::out_beat_t result_q, result_d;

	// shared unit
	saa_pkg::iter_cmd_t  icmd;
	saa_pkg::iter_stat_t iter_stat;
	logic [127:0]        iopa;
	logic [63:0]         iopb;
	logic [127:0]        ires;

	// scratch
	saa_pkg::sat_t     sa, sb, fm;
	saa_pkg::cnt_sat_t cs;
	logic [63:0]       rmag, rnd, fsrc;
	logic              is_avg;
	logic              item_fire;

	saa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode_q)
	);

	saa_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (icmd),
		.opa    (iopa),
		.opb    (iopb),
		.res    (ires),
		.stat   (iter_stat)
	);

	assign item_stall = (state_q != ST_IDLE);
	assign item_fire  = item_valid && !item_stall;
	assign is_avg     = (mode_q == saa_pkg::MODE_AVG) || (mode_q == saa_pkg::MODE_MEDIAN) ||
		(mode_q == saa_pkg::MODE_PCTILE);
	assign fsrc       = is_avg ? sum_q : spread_q;

	// operands for the shared unit, taken from registers on launch
	always_comb begin
		icmd.start = launch_q;
		icmd.op    = saa_pkg::IT_MUL;
		iopa       = '0;
		iopb       = '0;
		unique case (state_q)
			ST_W_DIV: begin
				icmd.op = saa_pkg::IT_DIV;
				iopa    = {64'd0, saa_pkg::mag(delta_q)};
				iopb    = {32'd0, count_q};
			end
			ST_W_MUL: begin
				iopa = {64'd0, saa_pkg::mag(delta_q)};
				iopb = saa_pkg::mag(t_q);
			end
			ST_A_MUL: begin
				iopa = {64'd0, saa_pkg::mag(v_q)};
				iopb = {32'd0, w_q};
			end
			ST_M_MUL1: begin
				iopa = {64'd0, saa_pkg::mag(delta_q)};
				iopb = {32'd0, w_q};
			end
			ST_M_DIV1, ST_M_DIV2: begin
				icmd.op = saa_pkg::IT_DIV;
				iopa    = ires;
				iopb    = {31'd0, total_q};
			end
			ST_M_SQ: begin
				iopa = {64'd0, saa_pkg::mag(delta_q)};
				iopb = saa_pkg::mag(delta_q);
			end
			ST_M_MUL2: begin
				iopa = {64'd0, t_q};
				iopb = {32'd0, n_q};
			end
			ST_M_MUL3: begin
				iopa = {64'd0, ires[63:0]};
				iopb = {32'd0, w_q};
			end
			ST_F_DIV: begin
				icmd.op = saa_pkg::IT_DIV;
				iopa    = {64'd0, saa_pkg::mag(fsrc)};
				iopb    = {32'd0, count_q};
			end
			ST_F_ROOT: begin
				icmd.op = saa_pkg::IT_ROOT;
				iopa    = {{(saa_pkg::PROD_W - saa_pkg::VAL_W - saa_pkg::FRAC_W){1'b0}},
					(t_q[63] ? 64'd0 : t_q), {saa_pkg::FRAC_W{1'b0}}};
			end
			default: begin
				icmd.op = saa_pkg::IT_MUL;
			end
		endcase
	end

	// count-mode rounding, halves away from zero
	always_comb begin
		rmag = saa_pkg::mag(sum_q);
		rnd  = {{saa_pkg::FRAC_W{1'b0}}, rmag[saa_pkg::VAL_W-1:saa_pkg::FRAC_W]} +
			{63'd0, rmag[saa_pkg::FRAC_W-1]};
		if (sum_q[63]) begin
			rnd = ~rnd + 64'd1;
		end
	end

	// sequencer and state update
	always_comb begin
		state_d      = state_q;
		launch_d     = 1'b0;
		delta_d      = delta_q;
		t_d          = t_q;
		n_d          = n_q;
		total_d      = total_q;
		qnz_d        = qnz_q;
		ores_d       = ores_q;
		okind_d      = okind_q;
		sum_d        = sum_q;
		count_d      = count_q;
		min_d        = min_q;
		max_d        = max_q;
		mean_d       = mean_q;
		spread_d     = spread_q;
		first_d      = first_q;
		last_d       = last_q;
		have_first_d = have_first_q;
		rvalid_d     = rvalid_q && result_stall;
		result_d     = result_q;
		ovf_set      = 1'b0;
		clr          = 1'b0;
		sa           = '0;
		sb           = '0;
		fm           = '0;
		cs           = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_FIN;
				unique case (op_q)
					saa_pkg::OPC_ADD: begin
						unique case (mode_q)
							saa_pkg::MODE_COUNT, saa_pkg::MODE_SUM, saa_pkg::MODE_DISTINCT: begin
								sa      = saa_pkg::sat_add(sum_q, v_q);
								sum_d   = sa.val;
								ovf_set = sa.ovf;
							end
							saa_pkg::MODE_AVG, saa_pkg::MODE_MEDIAN, saa_pkg::MODE_PCTILE: begin
								sa      = saa_pkg::sat_add(sum_q, v_q);
								cs      = saa_pkg::add_count(count_q, 32'd1);
								sum_d   = sa.val;
								count_d = cs.cnt;
								ovf_set = sa.ovf | cs.ovf;
							end
							saa_pkg::MODE_MIN: begin
								if ($signed(v_q) < $signed(min_q)) begin
									min_d = v_q;
								end
							end
							saa_pkg::MODE_MAX: begin
								if ($signed(v_q) > $signed(max_q)) begin
									max_d = v_q;
								end
							end
							saa_pkg::MODE_STDDEV, saa_pkg::MODE_VARIANCE: begin
								cs       = saa_pkg::add_count(count_q, 32'd1);
								sa       = saa_pkg::sat_sub(v_q, mean_q);
								count_d  = cs.cnt;
								delta_d  = sa.val;
								ovf_set  = sa.ovf | cs.ovf;
								state_d  = ST_W_DIV;
								launch_d = 1'b1;
							end
							saa_pkg::MODE_FIRST, saa_pkg::MODE_LAST: begin
								if (!have_first_q) begin
									first_d      = v_q;
									have_first_d = 1'b1;
								end
								last_d = v_q;
							end
							default: begin
								state_d = ST_FIN;
							end
						endcase
					end
					saa_pkg::OPC_WAVG: begin
						state_d  = ST_A_MUL;
						launch_d = 1'b1;
					end
					saa_pkg::OPC_MERGE: begin
						if (w_q != 32'd0) begin
							total_d  = {1'b0, count_q} + {1'b0, w_q};
							n_d      = count_q;
							cs       = saa_pkg::add_count(count_q, w_q);
							sa       = saa_pkg::sat_sub(v_q, mean_q);
							sb       = saa_pkg::sat_add(spread_q, {1'b0, os_q});
							count_d  = cs.cnt;
							delta_d  = sa.val;
							spread_d = sb.val;
							ovf_set  = cs.ovf | sa.ovf | sb.ovf;
							state_d  = ST_M_MUL1;
							launch_d = 1'b1;
						end
					end
					saa_pkg::OPC_CLEAR: begin
						clr          = 1'b1;
						sum_d        = '0;
						count_d      = '0;
						min_d        = saa_pkg::VMAX;
						max_d        = saa_pkg::VMIN;
						mean_d       = '0;
						spread_d     = '0;
						first_d      = '0;
						last_d       = '0;
						have_first_d = 1'b0;
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			// welford: mean moves by delta over the new count
			ST_W_DIV: begin
				if (iter_stat.done) begin
					fm      = saa_pkg::from_mag(delta_q[63], |ires[127:64], ires[63:0]);
					sa      = saa_pkg::sat_add(mean_q, fm.val);
					mean_d  = sa.val;
					ovf_set = fm.ovf | sa.ovf;
					state_d = ST_W_D2;
				end
			end
			ST_W_D2: begin
				sa       = saa_pkg::sat_sub(v_q, mean_q);
				t_d      = sa.val;
				ovf_set  = sa.ovf;
				state_d  = ST_W_MUL;
				launch_d = 1'b1;
			end
			// welford: spread gains delta times delta2 when positive
			ST_W_MUL: begin
				if (iter_stat.done) begin
					fm      = saa_pkg::from_mag(delta_q[63] ^ t_q[63], |ires[127:96],
						ires[95:32]);
					ovf_set = fm.ovf;
					if (!fm.val[63] && fm.val != 64'd0) begin
						sa       = saa_pkg::sat_add(spread_q, fm.val);
						spread_d = sa.val;
						ovf_set  = fm.ovf | sa.ovf;
					end
					state_d = ST_FIN;
				end
			end
			// weighted average: value times row count
			ST_A_MUL: begin
				if (iter_stat.done) begin
					fm      = saa_pkg::from_mag(v_q[63], |ires[127:64], ires[63:0]);
					sa      = saa_pkg::sat_add(sum_q, fm.val);
					cs      = saa_pkg::add_count(count_q, w_q);
					sum_d   = sa.val;
					count_d = cs.cnt;
					ovf_set = fm.ovf | sa.ovf | cs.ovf;
					state_d = ST_FIN;
				end
			end
			ST_M_MUL1: begin
				if (iter_stat.done) begin
					state_d  = ST_M_DIV1;
					launch_d = 1'b1;
				end
			end
			// merge: mean gains delta*w/total
			ST_M_DIV1: begin
				if (iter_stat.done) begin
					fm       = saa_pkg::from_mag(delta_q[63], |ires[127:64], ires[63:0]);
					sa       = saa_pkg::sat_add(mean_q, fm.val);
					mean_d   = sa.val;
					ovf_set  = fm.ovf | sa.ovf;
					state_d  = ST_M_SQ;
					launch_d = 1'b1;
				end
			end
			ST_M_SQ: begin
				if (iter_stat.done) begin
					fm       = saa_pkg::from_mag(1'b0, |ires[127:96], ires[95:32]);
					t_d      = fm.val;
					ovf_set  = fm.ovf;
					state_d  = ST_M_MUL2;
					launch_d = 1'b1;
				end
			end
			ST_M_MUL2: begin
				if (iter_stat.done) begin
					state_d  = ST_M_DIV2;
					launch_d = 1'b1;
				end
			end
			ST_M_DIV2: begin
				if (iter_stat.done) begin
					qnz_d    = |ires[127:64];
					state_d  = ST_M_MUL3;
					launch_d = 1'b1;
				end
			end
			// merge: spread gains the scaled squared delta
			ST_M_MUL3: begin
				if (iter_stat.done) begin
					fm       = saa_pkg::from_mag(1'b0, qnz_q | (|ires[127:64]), ires[63:0]);
					sa       = saa_pkg::sat_add(spread_q, fm.val);
					spread_d = sa.val;
					ovf_set  = fm.ovf | sa.ovf;
					state_d  = ST_FIN;
				end
			end
			// finalise by mode
			ST_FIN: begin
				ores_d  = '0;
				okind_d = saa_pkg::KIND_FIXED;
				state_d = ST_OUT;
				unique case (mode_q)
					saa_pkg::MODE_COUNT, saa_pkg::MODE_DISTINCT: begin
						ores_d  = rnd;
						okind_d = saa_pkg::KIND_INT;
					end
					saa_pkg::MODE_SUM: begin
						ores_d = sum_q;
					end
					saa_pkg::MODE_AVG, saa_pkg::MODE_MEDIAN, saa_pkg::MODE_PCTILE,
					saa_pkg::MODE_STDDEV, saa_pkg::MODE_VARIANCE: begin
						if (count_q != 32'd0) begin
							state_d  = ST_F_DIV;
							launch_d = 1'b1;
						end
					end
					saa_pkg::MODE_MIN: begin
						ores_d = (min_q == saa_pkg::VMAX) ? 64'd0 : min_q;
					end
					saa_pkg::MODE_MAX: begin
						ores_d = (max_q == saa_pkg::VMIN) ? 64'd0 : max_q;
					end
					saa_pkg::MODE_FIRST: begin
						if (have_first_q) begin
							ores_d = first_q;
						end else begin
							okind_d = saa_pkg::KIND_NULL;
						end
					end
					saa_pkg::MODE_LAST: begin
						ores_d = last_q;
					end
					default: begin
						ores_d = '0;
					end
				endcase
			end
			ST_F_DIV: begin
				if (iter_stat.done) begin
					fm      = saa_pkg::from_mag(fsrc[63], |ires[127:64], ires[63:0]);
					ovf_set = fm.ovf;
					if (mode_q == saa_pkg::MODE_STDDEV) begin
						t_d      = fm.val;
						state_d  = ST_F_ROOT;
						launch_d = 1'b1;
					end else begin
						ores_d  = fm.val;
						state_d = ST_OUT;
					end
				end
			end
			ST_F_ROOT: begin
				if (iter_stat.done) begin
					ores_d  = ires[63] ? saa_pkg::VMAX : ires[63:0];
					state_d = ST_OUT;
				end
			end
			// load the output register once it is free
			ST_OUT: begin
				if (!rvalid_q || !result_stall) begin
					result_d.result_value = ores_q;
					result_d.result_kind  = okind_q;
					result_d.saturated    = ovf_q;
					rvalid_d              = 1'b1;
					state_d               = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		ovf_d = clr ? 1'b0 : (ovf_q | ovf_set);
	end

	// control and aggregate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			launch_q     <= 1'b0;
			rvalid_q     <= 1'b0;
			sum_q        <= '0;
			count_q      <= '0;
			min_q        <= saa_pkg::VMAX;
			max_q        <= saa_pkg::VMIN;
			mean_q       <= '0;
			spread_q     <= '0;
			first_q      <= '0;
			last_q       <= '0;
			have_first_q <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			state_q      <= state_d;
			launch_q     <= launch_d;
			rvalid_q     <= rvalid_d;
			sum_q        <= sum_d;
			count_q      <= count_d;
			min_q        <= min_d;
			max_q        <= max_d;
			mean_q       <= mean_d;
			spread_q     <= spread_d;
			first_q      <= first_d;
			last_q       <= last_d;
			have_first_q <= have_first_d;
			ovf_q        <= ovf_d;
		end
	end

	// beat capture and working registers
	always_ff @(posedge clk) begin
		if (item_fire) begin
			op_q <= item.opcode;
			v_q  <= item.sample_value;
			w_q  <= item.weight;
			os_q <= item.other_spread;
		end
		delta_q  <= delta_d;
		t_q      <= t_d;
		n_q      <= n_d;
		total_q  <= total_d;
		qnz_q    <= qnz_d;
		ores_q   <= ores_d;
		okind_q  <= okind_d;
		result_q <= result_d;
	end

	assign result_valid = rvalid_q;
	assign result       = result_q;

	`SAA_ASSERT(a_rise_from_out, $rose(result_valid) |-> $past(state_q == ST_OUT), "result beat not from output step")
	`SAA_ASSERT_NEXT(a_accept_exec, item_valid && !item_stall, state_q == ST_EXEC, "accepted beat did not start")
	`SAA_ASSERT(a_unit_in_work, iter_stat.busy |-> (state_q != ST_IDLE && state_q != ST_OUT), "shared unit busy outside work")

endmodule
